@@ hw/rtl/iirbq_pkg.sv @@
package iirbq_pkg;

	// default build options
	localparam int FILTER_TAPS_DEF    = 3;
	localparam int COEF_FRAC_BITS_DEF = 14;

	// datapath widths
	localparam int SAMPLE_W  = 16;
	localparam int COEF_W    = 16;
	localparam int STATE_W   = 40;
	localparam int ACC_W     = 60;
	localparam int CHUNK_W   = 20;
	localparam int OPND_W    = CHUNK_W + 1;
	localparam int PROD_W    = COEF_W + OPND_W;
	localparam int PC_W      = 5;
	localparam int CFG_IDX_W = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_B0   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_B1   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_B2   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_A1   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_A2   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_FORM = 3'd5;

	// coefficient reset values
	localparam logic signed [COEF_W-1:0] B0_RST = 16'sd16384;

	// program entry points
	localparam logic [PC_W-1:0] PC_DISPATCH = 5'd0;
	localparam logic [PC_W-1:0] PC_DF_START = 5'd7;

	typedef enum logic [1:0] {
		ACC_KEEP,
		ACC_ZERO,
		ACC_D0,
		ACC_D1
	} acc_init_t;

	typedef enum logic [2:0] {
		CS_B0,
		CS_B1,
		CS_B2,
		CS_A1,
		CS_A2
	} coef_sel_t;

	typedef enum logic [2:0] {
		OP_X,
		OP_Y,
		OP_W1_LO,
		OP_W1_HI,
		OP_W2_LO,
		OP_W2_HI,
		OP_W_LO,
		OP_W_HI
	} opnd_sel_t;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_Y_SINGLE,
		ACT_TMP,
		ACT_W,
		ACT_DONE_TDF,
		ACT_DONE_DF
	} act_t;

	typedef enum logic [1:0] {
		JMP_NEXT,
		JMP_FORM,
		JMP_END
	} jmp_t;

	typedef struct packed {
		acc_init_t        acc_init;
		logic             mul_en;
		logic             neg;
		coef_sel_t        coef_sel;
		opnd_sel_t        opnd_sel;
		act_t             act;
		jmp_t             jmp;
		logic [PC_W-1:0]  target;
	} ucode_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] b0;
		logic signed [COEF_W-1:0] b1;
		logic signed [COEF_W-1:0] b2;
		logic signed [COEF_W-1:0] a1;
		logic signed [COEF_W-1:0] a2;
	} coef_set_t;

	typedef struct packed {
		logic                       clip;
		logic signed [SAMPLE_W-1:0] y;
	} res_t;

	function automatic ucode_t mk(input acc_init_t ai, input logic mul, input logic ng,
		input coef_sel_t cs, input opnd_sel_t op, input act_t ac, input jmp_t jp);
		ucode_t w;
		w.acc_init = ai;
		w.mul_en   = mul;
		w.neg      = ng;
		w.coef_sel = cs;
		w.opnd_sel = op;
		w.act      = ac;
		w.jmp      = jp;
		w.target   = PC_DF_START;
		return w;
	endfunction

	// microcode program: transposed form at 1..6, direct form at 7..17
	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t w;
		unique case (pc)
			5'd0:    w = mk(ACC_ZERO, 1'b0, 1'b0, CS_B0, OP_X,     ACT_NONE,     JMP_FORM);
			5'd1:    w = mk(ACC_D0,   1'b1, 1'b0, CS_B0, OP_X,     ACT_NONE,     JMP_NEXT);
			5'd2:    w = mk(ACC_D1,   1'b1, 1'b0, CS_B1, OP_X,     ACT_Y_SINGLE, JMP_NEXT);
			5'd3:    w = mk(ACC_KEEP, 1'b1, 1'b1, CS_A1, OP_Y,     ACT_NONE,     JMP_NEXT);
			5'd4:    w = mk(ACC_ZERO, 1'b1, 1'b0, CS_B2, OP_X,     ACT_TMP,      JMP_NEXT);
			5'd5:    w = mk(ACC_KEEP, 1'b1, 1'b1, CS_A2, OP_Y,     ACT_NONE,     JMP_NEXT);
			5'd6:    w = mk(ACC_KEEP, 1'b0, 1'b0, CS_B0, OP_X,     ACT_DONE_TDF, JMP_END);
			5'd7:    w = mk(ACC_ZERO, 1'b1, 1'b0, CS_A1, OP_W1_LO, ACT_NONE,     JMP_NEXT);
			5'd8:    w = mk(ACC_KEEP, 1'b1, 1'b0, CS_A1, OP_W1_HI, ACT_NONE,     JMP_NEXT);
			5'd9:    w = mk(ACC_KEEP, 1'b1, 1'b0, CS_A2, OP_W2_LO, ACT_NONE,     JMP_NEXT);
			5'd10:   w = mk(ACC_KEEP, 1'b1, 1'b0, CS_A2, OP_W2_HI, ACT_NONE,     JMP_NEXT);
			5'd11:   w = mk(ACC_ZERO, 1'b1, 1'b0, CS_B1, OP_W1_LO, ACT_W,        JMP_NEXT);
			5'd12:   w = mk(ACC_KEEP, 1'b1, 1'b0, CS_B1, OP_W1_HI, ACT_NONE,     JMP_NEXT);
			5'd13:   w = mk(ACC_KEEP, 1'b1, 1'b0, CS_B2, OP_W2_LO, ACT_NONE,     JMP_NEXT);
			5'd14:   w = mk(ACC_KEEP, 1'b1, 1'b0, CS_B2, OP_W2_HI, ACT_NONE,     JMP_NEXT);
			5'd15:   w = mk(ACC_KEEP, 1'b1, 1'b0, CS_B0, OP_W_LO,  ACT_NONE,     JMP_NEXT);
			5'd16:   w = mk(ACC_KEEP, 1'b1, 1'b0, CS_B0, OP_W_HI,  ACT_NONE,     JMP_NEXT);
			5'd17:   w = mk(ACC_KEEP, 1'b0, 1'b0, CS_B0, OP_X,     ACT_DONE_DF,  JMP_END);
			default: w = mk(ACC_KEEP, 1'b0, 1'b0, CS_B0, OP_X,     ACT_NONE,     JMP_END);
		endcase
		return w;
	endfunction

endpackage

@@ hw/rtl/iirbq_datapath.sv @@
module iirbq_datapath #(
	parameter int FILTER_TAPS    = iirbq_pkg::FILTER_TAPS_DEF,
	parameter int COEF_FRAC_BITS = iirbq_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 step_en,
	input  iirbq_pkg::ucode_t                    ctl,
	input  iirbq_pkg::coef_set_t                 coefs,
	input  logic signed [iirbq_pkg::SAMPLE_W-1:0] x,
	output iirbq_pkg::res_t                      res
);

	localparam int ACC_W   = iirbq_pkg::ACC_W;
	localparam int STATE_W = iirbq_pkg::STATE_W;
	localparam int CHUNK_W = iirbq_pkg::CHUNK_W;
	localparam int OPND_W  = iirbq_pkg::OPND_W;
	localparam int SMP_W   = iirbq_pkg::SAMPLE_W;
	localparam bit THREE   = (FILTER_TAPS >= 3);

	localparam logic signed [ACC_W-1:0] HALF_F  = ACC_W'(1) << (COEF_FRAC_BITS - 1);
	localparam logic signed [ACC_W-1:0] HALF_2F = ACC_W'(1) << (2 * COEF_FRAC_BITS - 1);
	localparam logic signed [ACC_W-1:0] ST_MAX  =
		{{(ACC_W-STATE_W+1){1'b0}}, {(STATE_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ST_MIN  =
		{{(ACC_W-STATE_W+1){1'b1}}, {(STATE_W-1){1'b0}}};
	localparam logic signed [ACC_W-1:0] SMP_MAX =
		{{(ACC_W-SMP_W+1){1'b0}}, {(SMP_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SMP_MIN =
		{{(ACC_W-SMP_W+1){1'b1}}, {(SMP_W-1){1'b0}}};

	function automatic logic signed [STATE_W-1:0] sat40(input logic signed [ACC_W-1:0] v);
		logic signed [STATE_W-1:0] r;
		if (v > ST_MAX) begin
			r = ST_MAX[STATE_W-1:0];
		end else if (v < ST_MIN) begin
			r = ST_MIN[STATE_W-1:0];
		end else begin
			r = v[STATE_W-1:0];
		end
		return r;
	endfunction

	function automatic iirbq_pkg::res_t sat16(input logic signed [ACC_W-1:0] v);
		iirbq_pkg::res_t r;
		if (v > SMP_MAX) begin
			r.clip = 1'b1;
			r.y    = SMP_MAX[SMP_W-1:0];
		end else if (v < SMP_MIN) begin
			r.clip = 1'b1;
			r.y    = SMP_MIN[SMP_W-1:0];
		end else begin
			r.clip = 1'b0;
			r.y    = v[SMP_W-1:0];
		end
		return r;
	endfunction

	logic signed [ACC_W-1:0]            acc_q;
	logic signed [STATE_W-1:0]          d0_q;
	logic signed [STATE_W-1:0]          d1_q;
	logic signed [STATE_W-1:0]          tmp_q;
	logic signed [SMP_W-1:0]            y_q;
	logic                               clip_q;

	logic signed [STATE_W-1:0]          d1_rd;
	logic signed [iirbq_pkg::COEF_W-1:0] coef_v;
	logic signed [OPND_W-1:0]           opnd_v;
	logic                               hi_sel;
	logic signed [iirbq_pkg::PROD_W-1:0] prod;
	logic signed [ACC_W-1:0]            prod_ext;
	logic signed [ACC_W-1:0]            addend;
	logic signed [ACC_W-1:0]            base;
	logic signed [ACC_W-1:0]            acc_d;
	logic signed [ACC_W-1:0]            rnd_f;
	logic signed [ACC_W-1:0]            rnd_2f;
	logic signed [ACC_W-1:0]            w_calc;
	iirbq_pkg::res_t                    y_single;

	// second delay only exists for the biquad build
	assign d1_rd = THREE ? d1_q : '0;

	// coefficient select
	always_comb begin
		case (ctl.coef_sel)
			iirbq_pkg::CS_B0: coef_v = coefs.b0;
			iirbq_pkg::CS_B1: coef_v = coefs.b1;
			iirbq_pkg::CS_B2: coef_v = THREE ? coefs.b2 : '0;
			iirbq_pkg::CS_A1: coef_v = coefs.a1;
			iirbq_pkg::CS_A2: coef_v = THREE ? coefs.a2 : '0;
			default:          coef_v = '0;
		endcase
	end

	// operand select, delay words go through in two 20-bit chunks
	always_comb begin
		case (ctl.opnd_sel)
			iirbq_pkg::OP_X:     opnd_v = OPND_W'(x);
			iirbq_pkg::OP_Y:     opnd_v = OPND_W'(y_q);
			iirbq_pkg::OP_W1_LO: opnd_v = {1'b0, d0_q[CHUNK_W-1:0]};
			iirbq_pkg::OP_W1_HI: opnd_v = {d0_q[STATE_W-1], d0_q[STATE_W-1:CHUNK_W]};
			iirbq_pkg::OP_W2_LO: opnd_v = {1'b0, d1_rd[CHUNK_W-1:0]};
			iirbq_pkg::OP_W2_HI: opnd_v = {d1_rd[STATE_W-1], d1_rd[STATE_W-1:CHUNK_W]};
			iirbq_pkg::OP_W_LO:  opnd_v = {1'b0, tmp_q[CHUNK_W-1:0]};
			iirbq_pkg::OP_W_HI:  opnd_v = {tmp_q[STATE_W-1], tmp_q[STATE_W-1:CHUNK_W]};
			default:             opnd_v = '0;
		endcase
	end

	assign hi_sel = (ctl.opnd_sel == iirbq_pkg::OP_W1_HI) ||
		(ctl.opnd_sel == iirbq_pkg::OP_W2_HI) || (ctl.opnd_sel == iirbq_pkg::OP_W_HI);

	// shared multiplier and accumulate
	assign prod     = coef_v * opnd_v;
	assign prod_ext = hi_sel ? (ACC_W'(prod) <<< CHUNK_W) : ACC_W'(prod);
	assign addend   = !ctl.mul_en ? '0 : (ctl.neg ? -prod_ext : prod_ext);

	always_comb begin
		case (ctl.acc_init)
			iirbq_pkg::ACC_KEEP: base = acc_q;
			iirbq_pkg::ACC_ZERO: base = '0;
			iirbq_pkg::ACC_D0:   base = ACC_W'(d0_q);
			iirbq_pkg::ACC_D1:   base = ACC_W'(d1_rd);
			default:             base = '0;
		endcase
	end

	assign acc_d = base + addend;

	// rounding, ties toward +inf
	assign rnd_f    = (acc_q + HALF_F) >>> COEF_FRAC_BITS;
	assign rnd_2f   = (acc_q + HALF_2F) >>> (2 * COEF_FRAC_BITS);
	assign w_calc   = (ACC_W'(x) <<< COEF_FRAC_BITS) - rnd_f;
	assign y_single = sat16(rnd_f);

	// result of the final step
	always_comb begin
		if (ctl.act == iirbq_pkg::ACT_DONE_DF) begin
			res = sat16(rnd_2f);
		end else begin
			res.clip = clip_q;
			res.y    = y_q;
		end
	end

	// accumulator and scratch registers
	always_ff @(posedge clk) begin
		if (step_en) begin
			acc_q <= acc_d;
			case (ctl.act)
				iirbq_pkg::ACT_Y_SINGLE: begin
					y_q    <= y_single.y;
					clip_q <= y_single.clip;
				end
				iirbq_pkg::ACT_TMP: tmp_q <= sat40(acc_q);
				iirbq_pkg::ACT_W:   tmp_q <= sat40(w_calc);
				default: ;
			endcase
		end
	end

	// delay line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d0_q <= '0;
			d1_q <= '0;
		end else if (step_en) begin
			case (ctl.act)
				iirbq_pkg::ACT_DONE_TDF: begin
					d0_q <= tmp_q;
					d1_q <= THREE ? sat40(acc_q) : '0;
				end
				iirbq_pkg::ACT_DONE_DF: begin
					d0_q <= tmp_q;
					d1_q <= THREE ? d0_q : '0;
				end
				default: ;
			endcase
		end
	end

endmodule

@@ hw/rtl/iir_biquad_filter_top.sv @@
// a result shows on out_valid once the microcode program of the selected form
// (transposed or direct) has run its steps; the final step stalls while an earlier
// result waits unaccepted. A new sample is taken only while the sequencer is idle,
// as the program drives one shared 16x21 multiplier, at most one product chunk per step
// reset: arst_n clears the sequencer, the output valid flag and the delay line,
// and loads the coefficient reset values (b0 = 1.0, others zero, transposed form)
module iir_biquad_filter_top #(
	parameter int FILTER_TAPS    = iirbq_pkg::FILTER_TAPS_DEF,
	parameter int COEF_FRAC_BITS = iirbq_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [iirbq_pkg::CFG_IDX_W-1:0]       cfg_addr,
	input  logic [iirbq_pkg::COEF_W-1:0]          cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [iirbq_pkg::SAMPLE_W-1:0] sample_in,
	input  logic                                  frame_end,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [iirbq_pkg::SAMPLE_W-1:0] sample_out,
	output logic                                  frame_end_out,
	output logic                                  clipped
);

	iirbq_pkg::coef_set_t                  coefs_q;
	logic                                  form_q;
	logic                                  busy_q;
	logic [iirbq_pkg::PC_W-1:0]            pc_q;
	logic signed [iirbq_pkg::SAMPLE_W-1:0] x_q;
	logic                                  fe_q;
	logic                                  out_valid_q;
	logic signed [iirbq_pkg::SAMPLE_W-1:0] sample_out_q;
	logic                                  fe_out_q;
	logic                                  clip_out_q;

	iirbq_pkg::ucode_t                     ctl;
	iirbq_pkg::res_t                       res;
	logic                                  is_end;
	logic                                  stall;
	logic                                  step_en;
	logic                                  in_acc;

	assign cfg_ready     = 1'b1;
	assign in_ready      = !busy_q;
	assign in_acc        = in_valid && !busy_q;
	assign out_valid     = out_valid_q;
	assign sample_out    = sample_out_q;
	assign frame_end_out = fe_out_q;
	assign clipped       = clip_out_q;

	// microcode fetch; final step waits for the output register to free up
	assign ctl     = iirbq_pkg::ucode_rom(pc_q);
	assign is_end  = (ctl.jmp == iirbq_pkg::JMP_END);
	assign stall   = is_end && out_valid_q && !out_ready;
	assign step_en = busy_q && !stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coefs_q.b0 <= iirbq_pkg::B0_RST;
			coefs_q.b1 <= '0;
			coefs_q.b2 <= '0;
			coefs_q.a1 <= '0;
			coefs_q.a2 <= '0;
			form_q     <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_addr)
				iirbq_pkg::CFG_B0:   coefs_q.b0 <= cfg_data;
				iirbq_pkg::CFG_B1:   coefs_q.b1 <= cfg_data;
				iirbq_pkg::CFG_B2:   coefs_q.b2 <= cfg_data;
				iirbq_pkg::CFG_A1:   coefs_q.a1 <= cfg_data;
				iirbq_pkg::CFG_A2:   coefs_q.a2 <= cfg_data;
				iirbq_pkg::CFG_FORM: form_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer: step counter with form dispatch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= iirbq_pkg::PC_DISPATCH;
		end else if (in_acc) begin
			busy_q <= 1'b1;
			pc_q   <= iirbq_pkg::PC_DISPATCH;
		end else if (step_en) begin
			unique case (ctl.jmp)
				iirbq_pkg::JMP_NEXT: pc_q <= pc_q + 1'b1;
				iirbq_pkg::JMP_FORM: pc_q <= form_q ? ctl.target : pc_q + 1'b1;
				iirbq_pkg::JMP_END:  busy_q <= 1'b0;
				default:             busy_q <= 1'b0;
			endcase
		end
	end

	// input request capture
	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q  <= sample_in;
			fe_q <= frame_end;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_en && is_end) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en && is_end) begin
			sample_out_q <= res.y;
			clip_out_q   <= res.clip;
			fe_out_q     <= fe_q;
		end
	end

	iirbq_datapath #(
		.FILTER_TAPS    (FILTER_TAPS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step_en),
		.ctl     (ctl),
		.coefs   (coefs_q),
		.x       (x_q),
		.res     (res)
	);

endmodule

@@ hw/rtl/iirbq_checker.sv @@
module iirbq_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  in_valid,
	input logic                                  in_ready,
	input logic                                  out_valid,
	input logic                                  out_ready,
	input logic signed [iirbq_pkg::SAMPLE_W-1:0] sample_out,
	input logic                                  clipped
);

	// one request at a time: the block goes busy right after taking one
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("in_ready still high after an input request");

	// a new result only comes out of a running computation
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a request in progress");

	// no result in the cycle right after a request
	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid))
		else $error("result too early after request");

	// a waiting result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(clipped))
		else $error("stalled result changed");

endmodule

bind iir_biquad_filter_top iirbq_checker u_iirbq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.sample_out (sample_out),
	.clipped    (clipped)
);

@@ verif/iirbq_tb_pkg.sv @@
`timescale 1ns / 100ps
package iirbq_tb_pkg;

	// meaning of the form select register
	typedef enum logic [0:0] {
		FORM_TDF2 = 1'b0,
		FORM_DF2  = 1'b1
	} filter_form_t;

	// indexes past the register map, a write there has no effect
	localparam logic [iirbq_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
	localparam logic [iirbq_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

endpackage

@@ verif/iir_biquad_filter_checker.sv @@
`timescale 1ns / 100ps
module iir_biquad_filter_checker #(
	parameter int FILTER_TAPS    = iirbq_pkg::FILTER_TAPS_DEF,
	parameter int COEF_FRAC_BITS = iirbq_pkg::COEF_FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	input  logic                                  cfg_ready,
	input  logic [iirbq_pkg::CFG_IDX_W-1:0]       cfg_addr,
	input  logic [iirbq_pkg::COEF_W-1:0]          cfg_data,
	input  logic                                  in_valid,
	input  logic                                  in_ready,
	input  logic signed [iirbq_pkg::SAMPLE_W-1:0] sample_in,
	input  logic                                  frame_end,
	input  logic                                  out_valid,
	input  logic                                  out_ready,
	input  logic signed [iirbq_pkg::SAMPLE_W-1:0] sample_out,
	input  logic                                  frame_end_out,
	input  logic                                  clipped,
	output int                                    mismatch_count,
	output int                                    pending_count
);
	import iirbq_pkg::*;
	import iirbq_tb_pkg::*;

	localparam longint STATE_MAX = (longint'(1) <<< (STATE_W - 1)) - 1;
	localparam longint STATE_MIN = -(longint'(1) <<< (STATE_W - 1));
	localparam longint OUT_MAX   = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
	localparam longint OUT_MIN   = -(longint'(1) <<< (SAMPLE_W - 1));
	localparam bit     BIQUAD    = (FILTER_TAPS >= 3);

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       frame_end;
		logic                       clip;
	} filtered_t;

	filtered_t    filtered_q [$];
	coef_set_t    coefs;
	filter_form_t form;
	longint       delay_line [2];
	int           errors;

	function automatic longint clamp_state(input longint v);
		if (v > STATE_MAX) return STATE_MAX;
		if (v < STATE_MIN) return STATE_MIN;
		return v;
	endfunction

	// add half an lsb, then floor: ties go toward +inf
	function automatic longint round_shift(input longint v, input int n);
		return (v + (longint'(1) <<< (n - 1))) >>> n;
	endfunction

	// one filter step, advances the delay line
	function automatic filtered_t filter_sample(input logic signed [SAMPLE_W-1:0] x_in,
		input logic fe);
		filtered_t res;
		longint    x, b0, b1, b2, a1, a2, s0, s1, acc, y, w;
		x  = longint'(x_in);
		b0 = longint'($signed(coefs.b0));
		b1 = longint'($signed(coefs.b1));
		a1 = longint'($signed(coefs.a1));
		b2 = BIQUAD ? longint'($signed(coefs.b2)) : 0;
		a2 = BIQUAD ? longint'($signed(coefs.a2)) : 0;
		s0 = delay_line[0];
		s1 = BIQUAD ? delay_line[1] : 0;
		w  = 0;
		if (form == FORM_TDF2) begin
			acc = b0 * x + s0;
			y   = round_shift(acc, COEF_FRAC_BITS);
		end else begin
			w   = clamp_state((x <<< COEF_FRAC_BITS)
				- round_shift(a1 * s0 + a2 * s1, COEF_FRAC_BITS));
			acc = b0 * w + b1 * s0 + b2 * s1;
			y   = round_shift(acc, 2 * COEF_FRAC_BITS);
		end
		// output saturation, the feedback sees the clamped value
		res.clip = (y > OUT_MAX) || (y < OUT_MIN);
		if (y > OUT_MAX)
			y = OUT_MAX;
		else if (y < OUT_MIN)
			y = OUT_MIN;
		if (form == FORM_TDF2) begin
			delay_line[0] = clamp_state(s1 + b1 * x - a1 * y);
			delay_line[1] = BIQUAD ? clamp_state(b2 * x - a2 * y) : 0;
		end else begin
			delay_line[1] = BIQUAD ? s0 : 0;
			delay_line[0] = w;
		end
		res.sample    = y[SAMPLE_W-1:0];
		res.frame_end = fe;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		filtered_t want;
		if (!arst_n) begin
			coefs.b0      = B0_RST;
			coefs.b1      = '0;
			coefs.b2      = '0;
			coefs.a1      = '0;
			coefs.a2      = '0;
			form          = FORM_TDF2;
			delay_line[0] = 0;
			delay_line[1] = 0;
			errors        = 0;
			filtered_q.delete();
			mismatch_count <= 0;
			pending_count  <= 0;
		end else begin
			// register write request
			if (cfg_valid && cfg_ready) begin
				case (cfg_addr)
					CFG_B0:   coefs.b0 = cfg_data;
					CFG_B1:   coefs.b1 = cfg_data;
					CFG_B2:   coefs.b2 = cfg_data;
					CFG_A1:   coefs.a1 = cfg_data;
					CFG_A2:   coefs.a2 = cfg_data;
					CFG_FORM: form = filter_form_t'(cfg_data[0]);
					default:  ;
				endcase
			end
			// result request against the oldest prediction
			if (out_valid && out_ready) begin
				if (filtered_q.size() == 0) begin
					$display("%0t: result with no sample pending: expected none, actual %0d",
						$time, sample_out);
					errors++;
				end else begin
					want = filtered_q.pop_front();
					if (sample_out !== want.sample) begin
						$display("%0t: sample_out expected %0d actual %0d",
							$time, $signed(want.sample), sample_out);
						errors++;
					end
					if (frame_end_out !== want.frame_end) begin
						$display("%0t: frame_end_out expected %0b actual %0b",
							$time, want.frame_end, frame_end_out);
						errors++;
					end
					if (clipped !== want.clip) begin
						$display("%0t: clipped expected %0b actual %0b",
							$time, want.clip, clipped);
						errors++;
					end
				end
			end
			// sample request
			if (in_valid && in_ready)
				filtered_q.push_back(filter_sample(sample_in, frame_end));
			mismatch_count <= errors;
			pending_count  <= filtered_q.size();
		end
	end

endmodule

@@ verif/iir_biquad_filter_top_tb.sv @@
`timescale 1ns / 100ps
module iir_biquad_filter_top_tb;
	import iirbq_pkg::*;
	import iirbq_tb_pkg::*;

	localparam int RANDOM_SAMPLES = 1850;
	localparam int STALL_LIMIT    = 4000;
	localparam int DRAIN_CYCLES   = 40;
	localparam int IDLE_PCT       = 21;
	localparam int CALM_FIRST     = 500;
	localparam int CALM_LAST      = 800;
	localparam int PAUSE_AT       = 1200;

	typedef enum logic [1:0] {
		SET_WILD,
		SET_TAME,
		SET_EXTREME
	} setting_kind_t;

	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [CFG_IDX_W-1:0]       cfg_addr  = '0;
	logic [COEF_W-1:0]          cfg_data  = '0;
	logic                       in_valid  = 1'b0;
	logic                       in_ready;
	logic signed [SAMPLE_W-1:0] sample_in = '0;
	logic                       frame_end = 1'b0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic signed [SAMPLE_W-1:0] sample_out;
	logic                       frame_end_out;
	logic                       clipped;
	int                         mismatch_count;
	int                         pending_count;
	bit                         calm          = 1'b0;
	int                         samples_sent  = 0;
	int                         directed_sent = 0;
	int                         cfg_writes    = 0;
	int                         settings_used = 0;
	int                         stall_cycles  = 0;

	always #5 clk = ~clk;

	iir_biquad_filter_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.sample_in     (sample_in),
		.frame_end     (frame_end),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.sample_out    (sample_out),
		.frame_end_out (frame_end_out),
		.clipped       (clipped)
	);

	iir_biquad_filter_checker u_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_addr       (cfg_addr),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.sample_in      (sample_in),
		.frame_end      (frame_end),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.sample_out     (sample_out),
		.frame_end_out  (frame_end_out),
		.clipped        (clipped),
		.mismatch_count (mismatch_count),
		.pending_count  (pending_count)
	);

	// receiver back-pressure
	always @(negedge clk)
		out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);

	// watchdog on cycles without any request
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_addr  <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_writes++;
	endtask

	// only called with nothing in flight
	task automatic program_filter(input coef_set_t c, input filter_form_t f,
		input bit [5:0] mask, input bit spare);
		logic [COEF_W-1:0] form_word;
		form_word    = '0;
		form_word[0] = f;
		if (mask[CFG_B0]) write_reg(CFG_B0, c.b0);
		if (mask[CFG_B1]) write_reg(CFG_B1, c.b1);
		if (mask[CFG_B2]) write_reg(CFG_B2, c.b2);
		if (mask[CFG_A1]) write_reg(CFG_A1, c.a1);
		if (mask[CFG_A2]) write_reg(CFG_A2, c.a2);
		if (spare) begin
			write_reg(CFG_SPARE_A, COEF_W'($urandom));
			write_reg(CFG_SPARE_B, COEF_W'($urandom));
		end
		if (mask[CFG_FORM]) write_reg(CFG_FORM, form_word);
		@(negedge clk);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic fe);
		@(negedge clk);
		while (!calm && ($urandom_range(0, 99) < IDLE_PCT)) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid  <= 1'b1;
		sample_in <= s;
		frame_end <= fe;
		do @(posedge clk); while (!in_ready);
		samples_sent++;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
	endtask

	function automatic coef_set_t make_coefs(input logic signed [COEF_W-1:0] b0, b1, b2, a1, a2);
		coef_set_t c;
		c.b0 = b0;
		c.b1 = b1;
		c.b2 = b2;
		c.a1 = a1;
		c.a2 = a2;
		return c;
	endfunction

	function automatic logic signed [COEF_W-1:0] pick_coef(input setting_kind_t kind,
		input bit feedback);
		case (kind)
			SET_WILD: return COEF_W'($urandom);
			SET_TAME: begin
				// small feedback keeps the poles inside the unit circle
				if (feedback)
					return COEF_W'($urandom_range(0, 16383) - 8192);
				return COEF_W'($urandom_range(0, 32767) - 16384);
			end
			default: begin
				case ($urandom_range(0, 3))
					0:       return 16'sh7fff;
					1:       return 16'sh8000;
					2:       return '0;
					default: return COEF_W'($urandom);
				endcase
			end
		endcase
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0:       return 16'sh7fff;
			1:       return 16'sh8000;
			2:       return SAMPLE_W'($urandom_range(0, 128) - 64);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	initial begin
		coef_set_t     c;
		setting_kind_t kind;
		bit [5:0]      only_form;
		int            phase_len;
		int            rand_sent;
		only_form           = '0;
		only_form[CFG_FORM] = 1'b1;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset settings pass the sample through
		send_sample(16'sh7fff, 1'b0);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'sh0000, 1'b1);
		send_sample(16'sh0001, 1'b0);
		send_sample(16'shffff, 1'b1);
		wait_drained();

		// every coefficient at an extreme, writes past the map must not land
		c = make_coefs(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
		program_filter(c, FORM_TDF2, '1, 1'b1);
		send_sample(16'sh7fff, 1'b0);
		send_sample(16'sh8000, 1'b1);
		send_sample(16'sh7fff, 1'b0);
		send_sample(16'sh8000, 1'b1);
		wait_drained();

		// switch form mid-stream, delay line kept as is
		program_filter(c, FORM_DF2, only_form, 1'b0);
		send_sample(16'sh0000, 1'b0);
		send_sample(16'sh7fff, 1'b0);
		send_sample(16'sh8000, 1'b1);
		wait_drained();

		// feedback gain of -2 drives the delay line into its 40-bit clamp
		c = make_coefs(16'sh4000, 16'sh0000, 16'sh0000, 16'sh8000, 16'sh0000);
		program_filter(c, FORM_DF2, '1, 1'b0);
		repeat (12) send_sample(16'sh7fff, 1'b0);
		wait_drained();
		directed_sent = samples_sent;

		// random settings, each followed by a burst of samples
		rand_sent = 0;
		while (rand_sent < RANDOM_SAMPLES) begin
			case ($urandom_range(0, 5))
				0:       kind = SET_WILD;
				1:       kind = SET_EXTREME;
				default: kind = SET_TAME;
			endcase
			c = make_coefs(pick_coef(kind, 1'b0), pick_coef(kind, 1'b0), pick_coef(kind, 1'b0),
				pick_coef(kind, 1'b1), pick_coef(kind, 1'b1));
			program_filter(c, filter_form_t'($urandom_range(0, 1)),
				($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'h3f,
				$urandom_range(0, 5) == 0);
			phase_len = $urandom_range(15, 90);
			for (int i = 0; i < phase_len && rand_sent < RANDOM_SAMPLES; i++) begin
				calm = (rand_sent >= CALM_FIRST) && (rand_sent < CALM_LAST);
				if (rand_sent == PAUSE_AT)
					wait_drained();
				send_sample(pick_sample(), $urandom_range(0, 7) == 0);
				rand_sent++;
			end
			wait_drained();
		end
		calm = 1'b0;
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("ran %0d samples (%0d directed) through %0d filter settings, %0d register writes",
			samples_sent, directed_sent, settings_used, cfg_writes);
		$display("both forms, output clipping, delay line clamp and a form switch mid-stream");
		if (mismatch_count == 0 && pending_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
